@@ rtl/linear_blend_vertex_skinning_assert.svh @@
// Assertion macros shared by the checker of the skinning block.
`ifndef LINEAR_BLEND_VERTEX_SKINNING_ASSERT_SVH
`define LINEAR_BLEND_VERTEX_SKINNING_ASSERT_SVH
// Same-cycle implication, disabled while reset is held.
`define LBVS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lbvs check failed");
// Next-cycle implication, disabled while reset is held.
`define LBVS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lbvs check failed");
// Next-cycle implication that also holds across reset.
`define LBVS_ASSERT_NEXT_ANY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("lbvs check failed");
`endif

@@ rtl/lbvs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package lbvs_pkg;
    localparam int POS_W          = 32;
    localparam int WORD_W         = 23;
    localparam int FRAC_W         = 16;
    localparam int IDX_W          = 7;
    localparam int CFG_W          = 8;
    localparam int COL_W          = 2;
    localparam int COLS           = 4;
    localparam int ROWS           = 3;
    localparam int LOAD_BONE_W    = WORD_W - COL_W;
    localparam int MAX_WORDS      = 8;
    localparam int TERM_W         = 48;
    localparam int ACC_W          = 51;
    localparam int WSUM_W         = 19;
    localparam int PROD_W         = 64;
    localparam int DIV_STEPS      = 32;
    localparam int LANE_STAGES    = 4;
    localparam int DEF_MAX_BONES  = 128;
    localparam int DEF_WEIGHTS    = 8;
    localparam int DEF_FRAC_BITS  = 16;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_SKIN = 1'b1
    } t_req;

    typedef logic signed [POS_W-1:0]  t_coord;
    typedef logic signed [TERM_W-1:0] t_term;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic [FRAC_W-1:0]        t_frac;
    typedef logic [WSUM_W-1:0]        t_wsum;

    // Column write request shared by all lanes.
    typedef struct packed {
        logic                   we;
        logic [COL_W-1:0]       col;
        logic [LOAD_BONE_W-1:0] bone;
    } t_load;
endpackage
`default_nettype wire

@@ rtl/lbvs_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface lbvs_in_if;
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic signed [lbvs_pkg::POS_W-1:0] pos_x;
    logic signed [lbvs_pkg::POS_W-1:0] pos_y;
    logic signed [lbvs_pkg::POS_W-1:0] pos_z;
    logic [lbvs_pkg::WORD_W-1:0]       weight_0;
    logic [lbvs_pkg::WORD_W-1:0]       weight_1;
    logic [lbvs_pkg::WORD_W-1:0]       weight_2;
    logic [lbvs_pkg::WORD_W-1:0]       weight_3;
    logic [lbvs_pkg::WORD_W-1:0]       weight_4;
    logic [lbvs_pkg::WORD_W-1:0]       weight_5;
    logic [lbvs_pkg::WORD_W-1:0]       weight_6;
    logic [lbvs_pkg::WORD_W-1:0]       weight_7;
    modport source (output valid, req_type, pos_x, pos_y, pos_z, weight_0, weight_1,
                    weight_2, weight_3, weight_4, weight_5, weight_6, weight_7,
                    input ready);
    modport sink (input valid, req_type, pos_x, pos_y, pos_z, weight_0, weight_1,
                  weight_2, weight_3, weight_4, weight_5, weight_6, weight_7,
                  output ready);
endinterface

interface lbvs_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [lbvs_pkg::POS_W-1:0] out_x;
    logic signed [lbvs_pkg::POS_W-1:0] out_y;
    logic signed [lbvs_pkg::POS_W-1:0] out_z;
    modport source (output valid, out_x, out_y, out_z, input ready);
    modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

interface lbvs_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [lbvs_pkg::CFG_W-1:0]  bone_count;
    modport source (output valid, bone_count, input ready);
    modport sink (input valid, bone_count, output ready);
endinterface
`default_nettype wire

@@ rtl/linear_blend_vertex_skinning.sv @@
// Linear blend vertex skinning, one request per cycle while o_out is not stalled.
// Input channel i_in: req_type 0 writes one column of a bone matrix (weight_0
// selects bone*4+column, pos_x/y/z are rows 0..2); req_type 1 skins a vertex
// with up to eight packed (bone, weight) words. Loads give no result.
// Configuration channel i_cfg sets bone_count; it is always ready.
// Output channel o_out carries one skinned position per vertex request.
// Each weight word has its own lane with a private copy of the bone table,
// split into one memory per matrix column, so a whole bone is read per cycle.
// A vertex result passes through four lane stages, two merge stages, one
// setup stage, a 32-stage restoring divider (one quotient bit per stage)
// and the output register. Throughput is one request per cycle while
// i_in.ready is high. The whole pipeline advances together;
// while the receiver holds off a waiting result, i_in.ready is low and every
// stage holds its contents, so nothing is lost.
// Reset clears bone_count and all valid flags; the bone table is not cleared
// and must be loaded before any bone it holds is used.
`timescale 1ns / 1ps
`default_nettype none
module linear_blend_vertex_skinning #(
    parameter int MAX_BONES          = lbvs_pkg::DEF_MAX_BONES,
    parameter int WEIGHTS_PER_VERTEX = lbvs_pkg::DEF_WEIGHTS,
    parameter int FRAC_BITS          = lbvs_pkg::DEF_FRAC_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lbvs_in_if.sink    i_in,
    lbvs_out_if.source o_out,
    lbvs_cfg_if.sink   i_cfg
);
    localparam int ST = lbvs_pkg::LANE_STAGES;

    logic                           en;
    logic                           accept;
    logic                           start;
    lbvs_pkg::t_load                load;
    logic [lbvs_pkg::CFG_W-1:0]     r_bone_count;
    logic [lbvs_pkg::WORD_W-1:0]    words [lbvs_pkg::MAX_WORDS];
    lbvs_pkg::t_term                term [lbvs_pkg::MAX_WORDS][lbvs_pkg::ROWS];
    lbvs_pkg::t_frac                frac [lbvs_pkg::MAX_WORDS];
    logic                           r_sv [ST];
    lbvs_pkg::t_coord               r_spos [ST][lbvs_pkg::ROWS];
    logic                           m_valid;
    lbvs_pkg::t_coord               m_pos [lbvs_pkg::ROWS];
    lbvs_pkg::t_acc                 m_acc [lbvs_pkg::ROWS];
    lbvs_pkg::t_wsum                m_wsum;
    logic                           d_valid [lbvs_pkg::ROWS];
    lbvs_pkg::t_coord               d_res [lbvs_pkg::ROWS];

    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;
    assign accept     = i_in.valid && en;
    assign start      = accept && (lbvs_pkg::t_req'(i_in.req_type) == lbvs_pkg::REQ_SKIN);

    assign load.we   = accept && (lbvs_pkg::t_req'(i_in.req_type) == lbvs_pkg::REQ_LOAD)
                       && (32'(i_in.weight_0[lbvs_pkg::WORD_W-1:lbvs_pkg::COL_W]) < MAX_BONES);
    assign load.col  = i_in.weight_0[lbvs_pkg::COL_W-1:0];
    assign load.bone = i_in.weight_0[lbvs_pkg::WORD_W-1:lbvs_pkg::COL_W];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bone_count <= '0;
        end else if (i_cfg.valid) begin
            r_bone_count <= i_cfg.bone_count;
        end
    end

    assign words[0] = i_in.weight_0;
    assign words[1] = i_in.weight_1;
    assign words[2] = i_in.weight_2;
    assign words[3] = i_in.weight_3;
    assign words[4] = i_in.weight_4;
    assign words[5] = i_in.weight_5;
    assign words[6] = i_in.weight_6;
    assign words[7] = i_in.weight_7;

    for (genvar l = 0; l < lbvs_pkg::MAX_WORDS; l++) begin : g_lane
        if (l < WEIGHTS_PER_VERTEX) begin : g_on
            lbvs_lane #(
                .MAX_BONES(MAX_BONES),
                .FRAC_BITS(FRAC_BITS)
            ) u_lane (
                .i_clk       (i_clk),
                .i_en        (en),
                .i_start     (start),
                .i_load      (load),
                .i_word      (words[l]),
                .i_pos_x     (i_in.pos_x),
                .i_pos_y     (i_in.pos_y),
                .i_pos_z     (i_in.pos_z),
                .i_bone_count(r_bone_count),
                .o_term      (term[l]),
                .o_frac      (frac[l])
            );
        end else begin : g_off
            for (genvar r = 0; r < lbvs_pkg::ROWS; r++) begin : g_row
                assign term[l][r] = '0;
            end
            assign frac[l] = '0;
        end
    end

    // Vertex flag and position ride alongside the lane stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < ST; s++) begin
                r_sv[s] <= 1'b0;
            end
        end else if (en) begin
            r_sv[0] <= start;
            for (int s = 1; s < ST; s++) begin
                r_sv[s] <= r_sv[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_spos[0][0] <= i_in.pos_x;
            r_spos[0][1] <= i_in.pos_y;
            r_spos[0][2] <= i_in.pos_z;
            for (int s = 1; s < ST; s++) begin
                r_spos[s] <= r_spos[s-1];
            end
        end
    end

    lbvs_merge u_merge (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(r_sv[ST-1]),
        .i_pos  (r_spos[ST-1]),
        .i_term (term),
        .i_frac (frac),
        .o_valid(m_valid),
        .o_pos  (m_pos),
        .o_acc  (m_acc),
        .o_wsum (m_wsum)
    );

    for (genvar r = 0; r < lbvs_pkg::ROWS; r++) begin : g_div
        lbvs_div u_div (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(m_valid),
            .i_acc  (m_acc[r]),
            .i_wsum (m_wsum),
            .i_pos  (m_pos[r]),
            .o_valid(d_valid[r]),
            .o_res  (d_res[r])
        );
    end

    // All three dividers run in lockstep; their flags agree.
    assign o_out.valid = d_valid[0] && d_valid[1] && d_valid[2];
    assign o_out.out_x = d_res[0];
    assign o_out.out_y = d_res[1];
    assign o_out.out_z = d_res[2];
endmodule
`default_nettype wire

@@ rtl/lbvs_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lbvs_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 128
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic                                       i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                                o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ rtl/lbvs_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lbvs_lane #(
    parameter int MAX_BONES = lbvs_pkg::DEF_MAX_BONES,
    parameter int FRAC_BITS = lbvs_pkg::DEF_FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic                          i_start,
    input  wire lbvs_pkg::t_load               i_load,
    input  wire logic [lbvs_pkg::WORD_W-1:0]   i_word,
    input  wire lbvs_pkg::t_coord              i_pos_x,
    input  wire lbvs_pkg::t_coord              i_pos_y,
    input  wire lbvs_pkg::t_coord              i_pos_z,
    input  wire logic [lbvs_pkg::CFG_W-1:0]    i_bone_count,
    output lbvs_pkg::t_term                    o_term [lbvs_pkg::ROWS],
    output lbvs_pkg::t_frac                    o_frac
);
    localparam int BONE_W = MAX_BONES > 1 ? $clog2(MAX_BONES) : 1;
    localparam int COL_DW = lbvs_pkg::ROWS * lbvs_pkg::POS_W;
    localparam logic signed [lbvs_pkg::PROD_W-1:0] HALF =
        lbvs_pkg::PROD_W'(64'sd1 <<< (FRAC_BITS - 1));

    logic [lbvs_pkg::IDX_W-1:0] idx;
    logic                       use_w;
    logic [COL_DW-1:0]          rd [lbvs_pkg::COLS];

    assign idx   = i_word[lbvs_pkg::WORD_W-1:lbvs_pkg::FRAC_W];
    assign use_w = i_start && (i_word != '0)
                   && ({1'b0, idx} < i_bone_count)
                   && (32'(idx) < MAX_BONES);

    // One memory per matrix column so that all four columns of a bone are read together.
    for (genvar c = 0; c < lbvs_pkg::COLS; c++) begin : g_col
        lbvs_ram #(
            .WIDTH(COL_DW),
            .DEPTH(MAX_BONES)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (i_load.we && (i_load.col == lbvs_pkg::COL_W'(c))),
            .i_waddr(BONE_W'(i_load.bone)),
            .i_wdata({i_pos_z, i_pos_y, i_pos_x}),
            .i_re   (i_en),
            .i_raddr(BONE_W'(idx)),
            .o_rdata(rd[c])
        );
    end

    logic                   r_use0, r_use1, r_use2;
    lbvs_pkg::t_frac        r_frac0, r_frac1, r_frac2;
    lbvs_pkg::t_coord       r_p0 [lbvs_pkg::ROWS];
    logic signed [lbvs_pkg::PROD_W-1:0] r_prod1 [lbvs_pkg::ROWS][lbvs_pkg::ROWS];
    lbvs_pkg::t_coord       r_tr1 [lbvs_pkg::ROWS];
    lbvs_pkg::t_coord       r_t2 [lbvs_pkg::ROWS];
    lbvs_pkg::t_term        r_term3 [lbvs_pkg::ROWS];
    lbvs_pkg::t_frac        r_frac3;
    lbvs_pkg::t_coord       n_t2 [lbvs_pkg::ROWS];

    function automatic logic signed [lbvs_pkg::PROD_W-1:0] PROD_W_EXT(
        input lbvs_pkg::t_coord v);
        return lbvs_pkg::PROD_W'(v);
    endfunction

    always_comb begin
        logic signed [lbvs_pkg::PROD_W-1:0] sum;
        for (int r = 0; r < lbvs_pkg::ROWS; r++) begin
            sum = PROD_W_EXT(r_tr1[r]);
            for (int k = 0; k < lbvs_pkg::ROWS; k++) begin
                sum = sum + ((r_prod1[r][k] + HALF) >>> FRAC_BITS);
            end
            if (sum > 64'sd2147483647) begin
                n_t2[r] = 32'sh7fffffff;
            end else if (sum < -64'sd2147483648) begin
                n_t2[r] = 32'sh80000000;
            end else begin
                n_t2[r] = sum[lbvs_pkg::POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_use0  <= use_w;
            r_frac0 <= i_word[lbvs_pkg::FRAC_W-1:0];
            r_p0[0] <= i_pos_x;
            r_p0[1] <= i_pos_y;
            r_p0[2] <= i_pos_z;

            r_use1  <= r_use0;
            r_frac1 <= r_frac0;
            for (int r = 0; r < lbvs_pkg::ROWS; r++) begin
                for (int k = 0; k < lbvs_pkg::ROWS; k++) begin
                    r_prod1[r][k] <= lbvs_pkg::t_coord'(rd[k][r*lbvs_pkg::POS_W +: lbvs_pkg::POS_W])
                                     * r_p0[k];
                end
                r_tr1[r] <= rd[3][r*lbvs_pkg::POS_W +: lbvs_pkg::POS_W];
            end

            r_use2  <= r_use1;
            r_frac2 <= r_frac1;
            r_t2    <= n_t2;

            for (int r = 0; r < lbvs_pkg::ROWS; r++) begin
                r_term3[r] <= r_use2
                    ? lbvs_pkg::TERM_W'(r_t2[r] * $signed({1'b0, r_frac2}))
                    : '0;
            end
            r_frac3 <= r_use2 ? r_frac2 : '0;
        end
    end

    assign o_term = r_term3;
    assign o_frac = r_frac3;
endmodule
`default_nettype wire

@@ rtl/lbvs_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lbvs_merge (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire lbvs_pkg::t_coord  i_pos [lbvs_pkg::ROWS],
    input  wire lbvs_pkg::t_term   i_term [lbvs_pkg::MAX_WORDS][lbvs_pkg::ROWS],
    input  wire lbvs_pkg::t_frac   i_frac [lbvs_pkg::MAX_WORDS],
    output logic                   o_valid,
    output lbvs_pkg::t_coord       o_pos [lbvs_pkg::ROWS],
    output lbvs_pkg::t_acc         o_acc [lbvs_pkg::ROWS],
    output lbvs_pkg::t_wsum        o_wsum
);
    localparam int PAIRS = lbvs_pkg::MAX_WORDS / 2;

    logic             r_va, r_vb;
    lbvs_pkg::t_coord r_posa [lbvs_pkg::ROWS];
    lbvs_pkg::t_coord r_posb [lbvs_pkg::ROWS];
    lbvs_pkg::t_acc   r_pair [PAIRS][lbvs_pkg::ROWS];
    lbvs_pkg::t_wsum  r_fpair [PAIRS];
    lbvs_pkg::t_acc   r_acc [lbvs_pkg::ROWS];
    lbvs_pkg::t_wsum  r_wsum;
    lbvs_pkg::t_acc   n_acc [lbvs_pkg::ROWS];
    lbvs_pkg::t_wsum  n_wsum;

    always_comb begin
        n_wsum = '0;
        for (int r = 0; r < lbvs_pkg::ROWS; r++) begin
            n_acc[r] = '0;
        end
        for (int p = 0; p < PAIRS; p++) begin
            n_wsum = n_wsum + r_fpair[p];
            for (int r = 0; r < lbvs_pkg::ROWS; r++) begin
                n_acc[r] = n_acc[r] + r_pair[p][r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_posa <= i_pos;
            r_posb <= r_posa;
            for (int p = 0; p < PAIRS; p++) begin
                r_fpair[p] <= lbvs_pkg::WSUM_W'(i_frac[2*p]) + lbvs_pkg::WSUM_W'(i_frac[2*p+1]);
                for (int r = 0; r < lbvs_pkg::ROWS; r++) begin
                    r_pair[p][r] <= lbvs_pkg::ACC_W'(i_term[2*p][r])
                                  + lbvs_pkg::ACC_W'(i_term[2*p+1][r]);
                end
            end
            r_acc  <= n_acc;
            r_wsum <= n_wsum;
        end
    end

    assign o_valid = r_vb;
    assign o_pos   = r_posb;
    assign o_acc   = r_acc;
    assign o_wsum  = r_wsum;
endmodule
`default_nettype wire

@@ rtl/lbvs_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lbvs_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire lbvs_pkg::t_acc    i_acc,
    input  wire lbvs_pkg::t_wsum   i_wsum,
    input  wire lbvs_pkg::t_coord  i_pos,
    output logic                   o_valid,
    output lbvs_pkg::t_coord       o_res
);
    localparam int N  = lbvs_pkg::DIV_STEPS;
    localparam int QW = lbvs_pkg::POS_W;
    localparam int RW = lbvs_pkg::WSUM_W;

    logic                 r_v    [N+1];
    logic                 r_neg  [N+1];
    logic                 r_zero [N+1];
    logic                 r_ovf  [N+1];
    logic [RW-1:0]        r_rem  [N+1];
    logic [QW-1:0]        r_low  [N+1];
    logic [QW-1:0]        r_q    [N+1];
    lbvs_pkg::t_wsum      r_w    [N+1];
    lbvs_pkg::t_coord     r_pos  [N+1];
    logic                 r_out_v;
    lbvs_pkg::t_coord     r_out;

    logic [lbvs_pkg::ACC_W-1:0] mag;
    lbvs_pkg::t_coord           n_out;

    assign mag = i_acc[lbvs_pkg::ACC_W-1] ? lbvs_pkg::ACC_W'(-i_acc) : i_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0]  <= i_acc[lbvs_pkg::ACC_W-1];
            r_zero[0] <= (i_wsum == '0);
            // Quotient at or above 2^32 saturates whatever its low bits are.
            r_ovf[0]  <= (mag[lbvs_pkg::ACC_W-1:QW] >= i_wsum);
            r_rem[0]  <= mag[lbvs_pkg::ACC_W-1:QW];
            r_low[0]  <= mag[QW-1:0];
            r_q[0]    <= '0;
            r_w[0]    <= i_wsum;
            r_pos[0]  <= i_pos;
        end
    end

    // One restoring step per stage.
    for (genvar s = 1; s <= N; s++) begin : g_step
        logic [RW:0] x;
        logic        ge;
        logic [RW:0] diff;
        assign x    = {r_rem[s-1], r_low[s-1][QW-1]};
        assign ge   = x >= {1'b0, r_w[s-1]};
        assign diff = x - {1'b0, r_w[s-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= r_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[s]  <= r_neg[s-1];
                r_zero[s] <= r_zero[s-1];
                r_ovf[s]  <= r_ovf[s-1];
                r_rem[s]  <= ge ? diff[RW-1:0] : x[RW-1:0];
                r_low[s]  <= {r_low[s-1][QW-2:0], 1'b0};
                r_q[s]    <= {r_q[s-1][QW-2:0], ge};
                r_w[s]    <= r_w[s-1];
                r_pos[s]  <= r_pos[s-1];
            end
        end
    end

    always_comb begin
        if (r_zero[N]) begin
            n_out = r_pos[N];
        end else if (r_ovf[N]) begin
            n_out = r_neg[N] ? 32'sh80000000 : 32'sh7fffffff;
        end else if (!r_neg[N]) begin
            n_out = r_q[N][QW-1] ? 32'sh7fffffff : $signed(r_q[N]);
        end else if (r_q[N][QW-1] && (r_q[N][QW-2:0] != '0)) begin
            n_out = 32'sh80000000;
        end else begin
            n_out = $signed(QW'(-r_q[N]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;
endmodule
`default_nettype wire

@@ rtl/lbvs_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "linear_blend_vertex_skinning_assert.svh"
module lbvs_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready
);
    // The input side is held exactly when a finished result is stalled.
    `LBVS_ASSERT_NOW(a_ready_follows_out, i_in_valid, i_in_ready == (!i_out_valid || i_out_ready))
    // A result that is not taken stays offered.
    `LBVS_ASSERT_NEXT(a_out_holds, i_out_valid && !i_out_ready, i_out_valid)
    // Reset empties the pipeline.
    `LBVS_ASSERT_NEXT_ANY(a_reset_clears, !i_rst_n, !i_out_valid)
endmodule

bind linear_blend_vertex_skinning lbvs_checker u_lbvs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready)
);
`default_nettype wire

@@ test/linear_blend_vertex_skinning_tb.sv @@
`timescale 1ns / 1ps
module linear_blend_vertex_skinning_tb;
    localparam int ROWS      = lbvs_pkg::ROWS;
    localparam int COLS      = lbvs_pkg::COLS;
    localparam int MAX_WORDS = lbvs_pkg::MAX_WORDS;
    localparam int WORD_W    = lbvs_pkg::WORD_W;
    localparam int FRAC_W    = lbvs_pkg::FRAC_W;
    localparam int POS_W     = lbvs_pkg::POS_W;
    localparam int COL_W     = lbvs_pkg::COL_W;
    localparam int CFG_W     = lbvs_pkg::CFG_W;
    localparam int IDX_W     = lbvs_pkg::IDX_W;
    localparam int FRAC_BITS = lbvs_pkg::DEF_FRAC_BITS;
    localparam int N_BONES = lbvs_pkg::DEF_MAX_BONES;
    localparam int N_FILL  = 32;
    localparam int N_ELEMS = N_BONES * ROWS * COLS;
    localparam int DRAIN_CYCLES = 60;

    typedef lbvs_pkg::t_coord t_coord;

    typedef struct packed {
        lbvs_pkg::t_req                   kind;
        t_coord                           x;
        t_coord                           y;
        t_coord                           z;
        logic [MAX_WORDS-1:0][WORD_W-1:0] w;
    } t_vertex_req;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_skinned_pos;

    typedef struct packed {
        t_vertex_req  req;
        logic         typed;
        t_skinned_pos pos;
    } t_directed_row;

    logic clk = 1'b0;
    logic rst_n;

    lbvs_in_if  in_if();
    lbvs_out_if out_if();
    lbvs_cfg_if cfg_if();

    linear_blend_vertex_skinning uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow of the bone table and of the bone count register.
    logic signed [POS_W-1:0] bone_tab [N_ELEMS];
    int unsigned             bone_limit;
    t_skinned_pos            pending_pos [$];
    int                      mismatches;
    bit                      src_idle_on;
    bit                      snk_idle_on;
    bit                      hold_off_now;

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint round_mul(input longint m, input longint p);
        return (m * p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic t_skinned_pos blend_vertex(input t_vertex_req r);
        longint       acc [ROWS];
        longint       pos [ROWS];
        longint       wsum;
        longint       t;
        int unsigned  lim;
        int unsigned  bone;
        int unsigned  base;
        t_skinned_pos res;
        pos[0] = r.x;
        pos[1] = r.y;
        pos[2] = r.z;
        wsum = 0;
        lim = (bone_limit < N_BONES) ? bone_limit : N_BONES;
        for (int k = 0; k < ROWS; k++) acc[k] = 0;
        for (int j = 0; j < MAX_WORDS; j++) begin
            bone = 32'(r.w[j][WORD_W-1:FRAC_W]);
            if (r.w[j] != '0 && bone < lim) begin
                base = bone * ROWS * COLS;
                for (int k = 0; k < ROWS; k++) begin
                    t = round_mul(bone_tab[base + k], pos[0])
                      + round_mul(bone_tab[base + 3 + k], pos[1])
                      + round_mul(bone_tab[base + 6 + k], pos[2])
                      + longint'(bone_tab[base + 9 + k]);
                    acc[k] += sat32(t) * longint'({1'b0, r.w[j][FRAC_W-1:0]});
                end
                wsum += longint'(r.w[j][FRAC_W-1:0]);
            end
        end
        for (int k = 0; k < ROWS; k++)
            if (wsum > 0) pos[k] = sat32(acc[k] / wsum);
        res.x = pos[0][POS_W-1:0];
        res.y = pos[1][POS_W-1:0];
        res.z = pos[2][POS_W-1:0];
        return res;
    endfunction

    function automatic void store_column(input t_vertex_req r);
        int unsigned bone;
        int unsigned col;
        bone = 32'(r.w[0][WORD_W-1:COL_W]);
        col = 32'(r.w[0][COL_W-1:0]);
        if (bone < N_BONES) begin
            bone_tab[bone * ROWS * COLS + col * ROWS]     = r.x;
            bone_tab[bone * ROWS * COLS + col * ROWS + 1] = r.y;
            bone_tab[bone * ROWS * COLS + col * ROWS + 2] = r.z;
        end
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 45);
    endfunction

    // Sends one request and records what it is expected to produce.
    task automatic send_request(input t_vertex_req r, input bit typed, input t_skinned_pos tp);
        int g;
        g = src_idle_on ? gap_len() : 0;
        if (g > 0) begin
            in_if.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_if.valid    <= 1'b1;
        in_if.req_type <= r.kind;
        in_if.pos_x    <= r.x;
        in_if.pos_y    <= r.y;
        in_if.pos_z    <= r.z;
        in_if.weight_0 <= r.w[0];
        in_if.weight_1 <= r.w[1];
        in_if.weight_2 <= r.w[2];
        in_if.weight_3 <= r.w[3];
        in_if.weight_4 <= r.w[4];
        in_if.weight_5 <= r.w[5];
        in_if.weight_6 <= r.w[6];
        in_if.weight_7 <= r.w[7];
        do @(posedge clk); while (!in_if.ready);
        if (r.kind == lbvs_pkg::REQ_LOAD) store_column(r);
        else pending_pos.push_back(typed ? tp : blend_vertex(r));
    endtask

    task automatic drain_pipe();
        in_if.valid <= 1'b0;
        while (pending_pos.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_bone_count(input int unsigned v);
        cfg_if.valid      <= 1'b1;
        cfg_if.bone_count <= v[CFG_W-1:0];
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        bone_limit = v & 8'hFF;
    endtask

    function automatic t_coord rand_value(input bit wide);
        int r;
        r = $urandom_range(0, 9);
        if (wide && r == 0) return 32'sh7FFF_FFFF;
        if (wide && r == 1) return 32'sh8000_0000;
        if (wide && r < 5) return $urandom();
        return $signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000;
    endfunction

    function automatic t_vertex_req rand_load(input int unsigned bone, input int unsigned col);
        t_vertex_req r;
        r = '0;
        r.kind = lbvs_pkg::REQ_LOAD;
        r.x = rand_value($urandom_range(0, 3) == 0);
        r.y = rand_value($urandom_range(0, 3) == 0);
        r.z = rand_value($urandom_range(0, 3) == 0);
        // Unused words on a load carry noise.
        for (int j = 1; j < MAX_WORDS; j++) r.w[j] = WORD_W'($urandom());
        r.w[0] = WORD_W'(bone * COLS + col);
        return r;
    endfunction

    // Bones that a vertex names are either loaded or skipped by the bone count.
    function automatic t_vertex_req rand_vertex();
        t_vertex_req r;
        int          c;
        int unsigned lim;
        lim = (bone_limit < N_BONES) ? bone_limit : N_BONES;
        r.kind = lbvs_pkg::REQ_SKIN;
        r.x = rand_value(1'b1);
        r.y = rand_value(1'b1);
        r.z = rand_value(1'b1);
        for (int j = 0; j < MAX_WORDS; j++) begin
            c = $urandom_range(0, 9);
            if (lim < N_BONES && $urandom_range(0, 3) == 0)
                r.w[j][WORD_W-1:FRAC_W] = IDX_W'($urandom_range(lim, N_BONES - 1));
            else
                r.w[j][WORD_W-1:FRAC_W] = IDX_W'($urandom_range(0, N_FILL - 1));
            if (c < 3) r.w[j] = '0;
            else if (c == 3) r.w[j][FRAC_W-1:0] = '0;
            else if (c == 4) r.w[j][FRAC_W-1:0] = 16'hFFFF;
            else r.w[j][FRAC_W-1:0] = FRAC_W'($urandom());
        end
        return r;
    endfunction

    function automatic t_directed_row vtx_row(input t_coord x, input t_coord y, input t_coord z,
                                              input logic [WORD_W-1:0] w);
        t_directed_row d;
        d.req.kind = lbvs_pkg::REQ_SKIN;
        d.req.x = x;
        d.req.y = y;
        d.req.z = z;
        for (int j = 0; j < MAX_WORDS; j++) d.req.w[j] = w ^ WORD_W'(j & 1);
        d.typed = 1'b1;
        d.pos = {x, y, z};
        return d;
    endfunction

    function automatic t_directed_row load_row(input logic [WORD_W-1:0] sel, input t_coord x,
                                               input t_coord y, input t_coord z);
        t_directed_row d;
        d = '0;
        d.req.kind = lbvs_pkg::REQ_LOAD;
        d.req.x = x;
        d.req.y = y;
        d.req.z = z;
        d.req.w[0] = sel;
        return d;
    endfunction

    always @(posedge clk) begin
        t_skinned_pos e;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (pending_pos.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d z=%0d",
                             out_if.out_x, out_if.out_y, out_if.out_z);
            end else begin
                e = pending_pos.pop_front();
                if (e.x !== out_if.out_x || e.y !== out_if.out_y || e.z !== out_if.out_z) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected (%0d, %0d, %0d) got (%0d, %0d, %0d)",
                                 e.x, e.y, e.z, out_if.out_x, out_if.out_y, out_if.out_z);
                end
            end
        end
    end

    // Receiver: random stalls, with one long hold-off on request.
    initial begin
        int g;
        out_if.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_off_now) begin
                out_if.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_off_now = 1'b0;
            end else if (snk_idle_on && $urandom_range(0, 2) == 0) begin
                g = gap_len();
                out_if.ready <= 1'b0;
                repeat (g + 1) @(posedge clk);
            end else begin
                out_if.ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    initial begin
        #3ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_directed_row dir_rows [$];
        int unsigned   phase_counts [6];
        t_skinned_pos  none;
        t_vertex_req   r;
        none = '0;
        mismatches = 0;
        bone_limit = 0;
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        hold_off_now = 1'b0;
        for (int i = 0; i < N_ELEMS; i++) bone_tab[i] = '0;
        rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.req_type <= lbvs_pkg::REQ_LOAD;
        in_if.pos_x <= '0;
        in_if.pos_y <= '0;
        in_if.pos_z <= '0;
        in_if.weight_0 <= '0;
        in_if.weight_1 <= '0;
        in_if.weight_2 <= '0;
        in_if.weight_3 <= '0;
        in_if.weight_4 <= '0;
        in_if.weight_5 <= '0;
        in_if.weight_6 <= '0;
        in_if.weight_7 <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.bone_count <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With bone_count at its reset value of zero every vertex passes through.
        dir_rows.push_back(vtx_row(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, '0));
        dir_rows.push_back(vtx_row(32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh1, 23'h7FFFFF));
        dir_rows.push_back(vtx_row(32'sh0001_0000, -32'sh0002_8000, 32'sh0, 23'h00FFFF));
        dir_rows.push_back(vtx_row(-32'sh1, 32'sh1, 32'sh5555_5555, 23'h7F0000));
        dir_rows.push_back(load_row(23'd801, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000));
        dir_rows.push_back(load_row(23'h7FFFFF, 32'sh1, 32'sh2, 32'sh3));
        dir_rows.push_back(load_row(23'd0, 32'sh0001_0000, 32'sh0, 32'sh0));
        dir_rows.push_back(load_row(23'd1, 32'sh0, 32'sh0001_0000, 32'sh0));
        dir_rows.push_back(load_row(23'd2, 32'sh0, 32'sh0, 32'sh0001_0000));
        dir_rows.push_back(load_row(23'd3, 32'sh0005_0000, -32'sh0003_0000, 32'sh1));
        dir_rows.push_back(load_row(23'd508, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sh1));
        dir_rows.push_back(load_row(23'd509, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0));
        dir_rows.push_back(load_row(23'd510, 32'sh0, 32'sh1, 32'sh7FFF_FFFF));
        dir_rows.push_back(load_row(23'd511, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
        dir_rows.push_back(vtx_row(32'sd123, -32'sd456, 32'sd789, 23'h000001));
        foreach (dir_rows[i])
            send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].pos);

        // Fill the low bones; bone 0 keeps the matrix loaded above.
        for (int b = 1; b < N_FILL; b++)
            for (int c = 0; c < COLS; c++)
                send_request(rand_load(b, c), 1'b0, none);
        drain_pipe();

        // Bone 0 is identity plus translation, bone 127 holds extremes.
        write_bone_count(N_BONES);
        r = '0;
        r.kind = lbvs_pkg::REQ_SKIN;
        r.x = 32'sh0002_0000;
        r.y = 32'sh0002_0000;
        r.z = 32'sh0002_0000;
        r.w[0] = {7'd0, 16'hFFFF};
        send_request(r, 1'b0, none);
        r.w[1] = {7'd127, 16'h8000};
        send_request(r, 1'b0, none);

        phase_counts = '{128, 255, 1, 64, 129, 0};
        phase_counts[5] = $urandom_range(2, 126);
        for (int ph = 0; ph < 6; ph++) begin
            drain_pipe();
            write_bone_count(phase_counts[ph]);
            src_idle_on = (ph != 3);
            snk_idle_on = (ph != 3);
            for (int n = 0; n < 68; n++) begin
                if (ph == 1 && n == 10) hold_off_now = 1'b1;
                if ($urandom_range(0, 4) == 0) begin
                    r = rand_load($urandom_range(0, N_BONES - 1), $urandom_range(0, COLS - 1));
                    if ($urandom_range(0, 5) == 0)
                        r.w[0] = WORD_W'($urandom_range(N_BONES * COLS, 23'h7FFFFF));
                end else begin
                    r = rand_vertex();
                end
                send_request(r, 1'b0, none);
            end
        end

        in_if.valid <= 1'b0;
        while (pending_pos.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/lbvs_pkg.sv
rtl/lbvs_if.sv
rtl/lbvs_ram.sv
rtl/lbvs_lane.sv
rtl/lbvs_merge.sv
rtl/lbvs_div.sv
rtl/linear_blend_vertex_skinning.sv
rtl/lbvs_checker.sv
test/linear_blend_vertex_skinning_tb.sv
